// ===== hw/rtl/secu_pkg.sv =====
// shared types, codes and character helpers for the string equality classifier
`default_nettype none

package secu_pkg;

  // verdict and per-pair class codes share one encoding
  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_SAME      = 2'd0;
  localparam verdict_t VERDICT_CASE      = 2'd1;
  localparam verdict_t VERDICT_LOOKALIKE = 2'd2;
  localparam verdict_t VERDICT_DISTINCT  = 2'd3;

  localparam int CHAR_BITS  = 8;
  localparam int LIMIT_BITS = 16;
  localparam int CFG_BITS   = 16;

  // register indexes on the config port
  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_COMPARE_LIMIT    = 2'd0;
  localparam cfg_index_t REG_FOLD_CASE        = 2'd1;
  localparam cfg_index_t REG_MATCH_LOOKALIKES = 2'd2;

  // pair queue, power of two depth
  localparam int QUEUE_DEPTH = 2;

  typedef logic [CHAR_BITS-1:0] char_t;

  localparam char_t CH_NUL     = 8'h00;
  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_LOWER_Z = 8'h7a;
  localparam char_t CH_CASE    = 8'h20;
  localparam char_t CH_I       = 8'h49;
  localparam char_t CH_L_LOW   = 8'h6c;
  localparam char_t CH_O       = 8'h4f;
  localparam char_t CH_O_LOW   = 8'h6f;
  localparam char_t CH_Z       = 8'h5a;
  localparam char_t CH_S       = 8'h53;
  localparam char_t CH_ONE     = 8'h31;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_TWO     = 8'h32;
  localparam char_t CH_FIVE    = 8'h35;

  // one classified pair on its way from front to back
  typedef struct packed {
    logic     is_term;
    logic     second_nz;
    verdict_t cls;
  } pair_entry_t;

  function automatic char_t upper_ascii(input char_t b);
    char_t r;
    r = b;
    if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
      r = b - CH_CASE;
    end
    return r;
  endfunction

  function automatic char_t glyph_class(input char_t b);
    char_t r;
    r = b;
    if (b == CH_I || b == CH_L_LOW) begin
      r = CH_ONE;
    end else if (b == CH_O || b == CH_O_LOW) begin
      r = CH_ZERO;
    end else if (b == CH_Z) begin
      r = CH_TWO;
    end else if (b == CH_S) begin
      r = CH_FIVE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/secu_front.sv =====
// front stage: accepts character pairs and classifies them
`default_nettype none

module secu_front
  import secu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire char_t       first_char,
  input  wire char_t       second_char,
  input  wire logic        fold_case,
  input  wire logic        match_lookalikes,
  output logic             push_valid,
  output pair_entry_t      push_entry,
  input  wire logic        push_ready
);

  logic        front_valid;
  pair_entry_t front_entry;
  pair_entry_t entry_next;

  always_comb begin
    entry_next.is_term   = (first_char == CH_NUL);
    entry_next.second_nz = (second_char != CH_NUL);
    if (first_char == second_char) begin
      entry_next.cls = VERDICT_SAME;
    end else if (fold_case && upper_ascii(first_char) == upper_ascii(second_char)) begin
      entry_next.cls = VERDICT_CASE;
    end else if (match_lookalikes &&
                 glyph_class(first_char) == glyph_class(second_char)) begin
      entry_next.cls = VERDICT_LOOKALIKE;
    end else begin
      entry_next.cls = VERDICT_DISTINCT;
    end
  end

  assign in_ready   = !front_valid || push_ready;
  assign push_valid = front_valid;
  assign push_entry = front_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      front_valid <= 1'b1;
    end else if (push_ready) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      front_entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/secu_queue.sv =====
// short queue of classified pairs between front and back
`default_nettype none

module secu_queue
  import secu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire pair_entry_t push_entry,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output pair_entry_t      pop_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pair_entry_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/secu_back.sv =====
// back stage: position and flag tracking, verdict register
`default_nettype none

module secu_back
  import secu_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pop_valid,
  output logic                       pop_ready,
  input  wire pair_entry_t           pop_entry,
  input  wire logic [LIMIT_BITS-1:0] compare_limit,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output verdict_t                   verdict
);

  localparam int CMP_W = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  logic [COUNT_BITS-1:0] position;
  logic                  case_seen;
  logic                  lookalike_seen;
  logic                  limit_reached;
  logic                  mismatch_seen;
  logic                  do_pop;
  logic                  at_limit;
  verdict_t              verdict_next;

  assign pop_ready = !pop_entry.is_term || !out_valid || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign at_limit  = (compare_limit != '0) &&
                     (CMP_W'(position) >= CMP_W'(compare_limit));

  always_comb begin
    if (mismatch_seen || (!limit_reached && pop_entry.second_nz)) begin
      verdict_next = VERDICT_DISTINCT;
    end else if (case_seen) begin
      verdict_next = VERDICT_CASE;
    end else if (lookalike_seen) begin
      verdict_next = VERDICT_LOOKALIKE;
    end else begin
      verdict_next = VERDICT_SAME;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      case_seen      <= 1'b0;
      lookalike_seen <= 1'b0;
      limit_reached  <= 1'b0;
      mismatch_seen  <= 1'b0;
    end else if (do_pop) begin
      if (pop_entry.is_term) begin
        position       <= '0;
        case_seen      <= 1'b0;
        lookalike_seen <= 1'b0;
        limit_reached  <= 1'b0;
        mismatch_seen  <= 1'b0;
      end else if (!mismatch_seen && !limit_reached) begin
        if (at_limit) begin
          limit_reached <= 1'b1;
        end else begin
          case (pop_entry.cls)
            VERDICT_CASE:      case_seen      <= 1'b1;
            VERDICT_LOOKALIKE: lookalike_seen <= 1'b1;
            VERDICT_DISTINCT:  mismatch_seen  <= 1'b1;
            default:           ;
          endcase
          if (position != '1) begin
            position <= position + COUNT_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pop && pop_entry.is_term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_entry.is_term) begin
      verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/string_equality_classifier_unit.sv =====
// top level of the string equality classifier
`default_nettype none

// Compares two byte strings fed as one character pair per item on the input
// channel and returns one verdict per string pair on the output channel when
// the first string's terminator (a zero byte in first_char) arrives. The
// verdict is 0 same, 1 differs in ASCII case (fold_case set; wins over
// lookalikes), 2 differs by lookalikes such as I/l/1, O/o/0, Z/2, S/5
// (match_lookalikes set), or 3 distinct. compare_limit caps how many pairs
// are compared; 0 compares the whole string. Items are taken at a sustained
// rate of one per clock cycle while the output is not stalled. A verdict
// moves from the front classify register, which loads on the accepting edge,
// through the queue to the back flag update, which loads the verdict
// register. A stalled output lets the queue fill, after which the input
// stalls too. Config writes must only be made while no string pair is in
// flight.

module string_equality_classifier_unit
  import secu_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // config write port
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  // character pair input
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          first_char,
  input  wire logic [7:0]          second_char,
  // verdict output
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               verdict
);

  // config registers
  logic [LIMIT_BITS-1:0] compare_limit;
  logic                  fold_case;
  logic                  match_lookalikes;

  // front to queue
  logic        push_valid;
  logic        push_ready;
  pair_entry_t push_entry;

  // queue to back
  logic        pop_valid;
  logic        pop_ready;
  pair_entry_t pop_entry;

  // unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      compare_limit    <= '0;
      fold_case        <= 1'b0;
      match_lookalikes <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COMPARE_LIMIT:    compare_limit    <= cfg_data[LIMIT_BITS-1:0];
        REG_FOLD_CASE:        fold_case        <= cfg_data[0];
        REG_MATCH_LOOKALIKES: match_lookalikes <= cfg_data[0];
        default:              ;
      endcase
    end
  end

  // classify each pair as it comes in
  secu_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .first_char       (first_char),
    .second_char      (second_char),
    .fold_case        (fold_case),
    .match_lookalikes (match_lookalikes),
    .push_valid       (push_valid),
    .push_entry       (push_entry),
    .push_ready       (push_ready)
  );

  // decouples front from a stalled verdict
  secu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // running flags, limit handling and verdict register
  secu_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .compare_limit (compare_limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .verdict       (verdict)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/secu_checker.sv =====
// port level checks for the string equality classifier
`default_nettype none

module secu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] verdict
);

  // a stalled verdict holds
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict dropped or changed while stalled");

  // a verdict passes front, queue and back, so nothing comes out right after reset
  a_no_early_verdict: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid)
    else $error("verdict shown too soon after reset");

  // front and queue are empty after reset
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  // a taken or absent verdict lets the back pop, so the queue leaves room
  a_ready_after_out_ready: assert property (@(posedge clk) disable iff (rst)
    $past(out_ready) |-> in_ready)
    else $error("input stalled although the output was ready");

endmodule

bind string_equality_classifier_unit secu_checker u_secu_checker (.*);

`default_nettype wire

// ===== tb/string_equality_classifier_unit_test.sv =====
// testbench for the string equality classifier: directed table, random strings, scoreboard
`timescale 1ns / 1ps

module string_equality_classifier_unit_test;
  import secu_pkg::*;

  localparam int COUNT_BITS = 16;

  // one item of either string, zero ends a string
  localparam char_t NUL      = 8'h00;
  localparam char_t CASE_BIT = 8'h20;

  // index that no register answers to, writes there must be dropped
  localparam cfg_index_t REG_UNUSED = 2'd3;

  // cycles to let the pipeline empty after the last verdict (three deep plus margin)
  localparam int SETTLE_CYCLES = 8;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int DIRECTED_ROWS   = 25;

  // characters that take part in lookalike matching
  localparam bit [8*10-1:0] GLYPHS    = "IlOoZS1025";
  localparam bit [8*3-1:0]  ONE_LIKE  = "Il1";
  localparam bit [8*3-1:0]  ZERO_LIKE = "Oo0";

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_write   = 1'b0;
  logic [1:0]          cfg_index   = REG_COMPARE_LIMIT;
  logic [CFG_BITS-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [7:0]          first_char  = NUL;
  logic [7:0]          second_char = NUL;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [1:0]          verdict;

  // register shadows
  logic [LIMIT_BITS-1:0] limit_reg = '0;
  logic                  fold_reg  = 1'b0;
  logic                  look_reg  = 1'b0;

  // comparison state of the string pair in progress
  logic [COUNT_BITS-1:0] pos       = '0;
  logic                  case_flag = 1'b0;
  logic                  look_flag = 1'b0;
  logic                  limit_hit = 1'b0;
  logic                  diverged  = 1'b0;

  verdict_t verdicts_due [$];
  int       mismatches = 0;
  bit       idle_on    = 1'b1;
  int       stall_left = 0;

  // one row of the directed script; the config fields count only when set_cfg is high
  typedef struct packed {
    bit                    set_cfg;
    logic [LIMIT_BITS-1:0] limit;
    bit                    fold;
    bit                    look;
    char_t                 lhs;
    char_t                 rhs;
    bit                    typed;
    verdict_t              want;
  } script_row_t;

  script_row_t script [DIRECTED_ROWS];

  string_equality_classifier_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_char(first_char),
    .second_char(second_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .verdict(verdict)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ascii upper-casing, letters a to z only
  function automatic char_t upcase(input char_t c);
    return (c >= "a" && c <= "z") ? char_t'(c - CASE_BIT) : c;
  endfunction

  // collapse lookalike letters onto the digit they resemble
  function automatic char_t glyph(input char_t c);
    case (c)
      "I", "l": return "1";
      "O", "o": return "0";
      "Z":      return "2";
      "S":      return "5";
      default:  return c;
    endcase
  endfunction

  // advance the comparison by one character pair; a terminator in the first string
  // yields the verdict and clears the state
  task automatic score_pair(input char_t a, input char_t b, output bit gives,
                            output verdict_t v);
    gives = (a == NUL);
    v     = VERDICT_SAME;
    if (gives) begin
      // second string still going counts only when the limit did not cut it off
      if (diverged || (!limit_hit && b != NUL)) begin
        v = VERDICT_DISTINCT;
      end else if (case_flag) begin
        v = VERDICT_CASE;
      end else if (look_flag) begin
        v = VERDICT_LOOKALIKE;
      end
      pos       = '0;
      case_flag = 1'b0;
      look_flag = 1'b0;
      limit_hit = 1'b0;
      diverged  = 1'b0;
    end else if (!diverged && !limit_hit) begin
      if (limit_reg != 0 && pos >= limit_reg) begin
        limit_hit = 1'b1;
      end else begin
        if (a == b) begin
          // identical bytes
        end else if (fold_reg && upcase(a) == upcase(b)) begin
          case_flag = 1'b1;
        end else if (look_reg && glyph(a) == glyph(b)) begin
          look_flag = 1'b1;
        end else begin
          diverged = 1'b1;
        end
        // position counter saturates
        if (pos != '1) begin
          pos = pos + 1'b1;
        end
      end
    end
  endtask

  // offer one character pair, hold it until taken, then record any verdict it causes;
  // a typed verdict replaces the predicted one in the scoreboard
  task automatic send_pair(input char_t a, input char_t b, input bit typed,
                           input verdict_t typed_v);
    bit       gives;
    verdict_t v;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    first_char  <= a;
    second_char <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    score_pair(a, b, gives, v);
    if (gives) begin
      verdicts_due.push_back(typed ? typed_v : v);
    end
  endtask

  // drop valid, let every verdict come back, then give the pipeline time to empty
  // of pairs that produce nothing
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // single register write, shadowed only once the edge has taken it
  task automatic put_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] word);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    case (idx)
      REG_COMPARE_LIMIT:    limit_reg = word[LIMIT_BITS-1:0];
      REG_FOLD_CASE:        fold_reg  = word[0];
      REG_MATCH_LOOKALIKES: look_reg  = word[0];
      default: ;
    endcase
  endtask

  // write all registers back to back; the one-bit registers get junk in their upper
  // bits, and a stray write to the unused index must change nothing
  task automatic write_regs(input logic [LIMIT_BITS-1:0] limit, input bit fold,
                            input bit look);
    logic [CFG_BITS-1:0] word;
    put_reg(REG_COMPARE_LIMIT, limit);
    word    = CFG_BITS'($urandom);
    word[0] = fold;
    put_reg(REG_FOLD_CASE, word);
    word    = CFG_BITS'($urandom);
    word[0] = look;
    put_reg(REG_MATCH_LOOKALIKES, word);
    put_reg(REG_UNUSED, CFG_BITS'($urandom));
    cfg_write <= 1'b0;
  endtask

  // character mix leaning on letters and lookalikes
  function automatic char_t any_char();
    case ($urandom_range(0, 3))
      0:       return GLYPHS[8*$urandom_range(0, 9) +: 8];
      1:       return ($urandom_range(0, 1) == 1) ? char_t'("a" + $urandom_range(0, 25))
                                                  : char_t'("A" + $urandom_range(0, 25));
      2:       return char_t'("0" + $urandom_range(0, 9));
      default: return char_t'($urandom_range(1, 255));
    endcase
  endfunction

  // a random first string and a second one derived from it with case flips,
  // lookalike swaps, stray bytes, and now and then one character more or less
  task automatic send_string_pair(output int n);
    char_t lhs [$];
    char_t rhs [$];
    char_t c;
    int    len;
    int    r;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      lhs.push_back(any_char());
    end
    foreach (lhs[i]) begin
      c = lhs[i];
      r = $urandom_range(0, 15);
      if (r == 0 && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) begin
        c = c ^ CASE_BIT;
      end else if (r == 1) begin
        case (c)
          "I", "l", "1": c = ONE_LIKE[8*$urandom_range(0, 2) +: 8];
          "O", "o", "0": c = ZERO_LIKE[8*$urandom_range(0, 2) +: 8];
          "Z":           c = "2";
          "2":           c = "Z";
          "S":           c = "5";
          "5":           c = "S";
          default: ;
        endcase
      end else if (r == 2) begin
        c = char_t'($urandom_range(1, 255));
      end
      rhs.push_back(c);
    end
    r = $urandom_range(0, 7);
    if (r == 0 && rhs.size() > 0) begin
      void'(rhs.pop_back());
    end else if (r == 1) begin
      rhs.push_back(any_char());
    end
    // pairs run up to and including the first string's terminator
    n = 0;
    for (int i = 0; i <= lhs.size(); i++) begin
      send_pair((i < lhs.size()) ? lhs[i] : NUL, (i < rhs.size()) ? rhs[i] : NUL,
                1'b0, VERDICT_SAME);
      n++;
    end
  endtask

  // verdict side: check every taken verdict against the oldest expectation,
  // and stall at random while idling is on
  always @(posedge clk) begin : verdict_side
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict: expected none, actual %0d", verdict);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (verdict !== want) begin
          $error("verdict: expected %0d, actual %0d", want, verdict);
          mismatches++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int sent;
    int n;

    // directed script: reset state, each kind of difference, priority of case over
    // lookalike, both length mismatches, the limit cutting off a longer second
    // string, and the extreme limit with lookalikes off
    script = '{
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b1, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "A",   "A",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "a",   "A",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b1, VERDICT_DISTINCT},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   "x",   1'b1, VERDICT_DISTINCT},
      '{1'b0, 16'd0,     1'b0, 1'b0, "x",   NUL,   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b1, VERDICT_DISTINCT},
      '{1'b1, 16'd0,     1'b1, 1'b1, "a",   "A",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "l",   "1",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "O",   "0",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "S",   "5",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "b",   "B",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b0, VERDICT_SAME},
      '{1'b1, 16'd2,     1'b0, 1'b1, "A",   "A",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, 8'h80, 8'h80, 1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "C",   "x",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   "y",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, "A",   "A",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   "B",   1'b1, VERDICT_DISTINCT},
      '{1'b1, 16'hFFFF,  1'b1, 1'b0, "I",   "1",   1'b0, VERDICT_SAME},
      '{1'b0, 16'd0,     1'b0, 1'b0, NUL,   NUL,   1'b1, VERDICT_DISTINCT}
    };

    // synchronous reset
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].set_cfg) begin
        wait_quiet();
        write_regs(script[i].limit, script[i].fold, script[i].look);
      end
      send_pair(script[i].lhs, script[i].rhs, script[i].typed, script[i].want);
    end

    // random phases, each under its own register setting; the extremes of the limit
    // come first, and phases 2 and 5 run without any idling
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      case (ph)
        0:       write_regs(16'd0, 1'b1, 1'b1);
        1:       write_regs(16'd1, 1'b0, 1'b1);
        2:       write_regs(16'hFFFF, 1'b1, 1'b1);
        3:       write_regs(16'd3, 1'b1, 1'b0);
        4:       write_regs(16'($urandom_range(1, 12)), 1'($urandom), 1'($urandom));
        default: write_regs(16'd0, 1'b0, 1'b0);
      endcase
      idle_on <= (ph % 3 != 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          // loose pair: any byte on either side, zeros included
          send_pair(($urandom_range(0, 5) == 0) ? NUL : char_t'($urandom_range(1, 255)),
                    ($urandom_range(0, 3) == 0) ? NUL : char_t'($urandom_range(1, 255)),
                    1'b0, VERDICT_SAME);
          sent++;
        end else begin
          send_string_pair(n);
          sent += n;
        end
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
